[hw/rtl/dwts_pkg.sv]
// ----------------------------------------------------------------------------
// dwts_pkg
// Shared types, constants and helper functions for the daily window time
// switch: register map, state and result records, BCD helpers, segment table.
// ----------------------------------------------------------------------------
package dwts_pkg;

  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int CYC_W      = 8;
  localparam int SEG_W      = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 4;
  localparam int DIDX_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int TOD_W      = 12;

  localparam logic MODE_SET = 1'b1;

  localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7f;
  localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HOUR    = 3'd0,
    REG_START_MINUTE  = 3'd1,
    REG_END_HOUR      = 3'd2,
    REG_END_MINUTE    = 3'd3,
    REG_CYCLE_MINUTES = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [HOUR_W-1:0] start_hour;
    logic [MIN_W-1:0]  start_minute;
    logic [HOUR_W-1:0] end_hour;
    logic [MIN_W-1:0]  end_minute;
    logic [CYC_W-1:0]  cycle_minutes;
  } dwts_cfg_t;

  // digits[0] = hour tens ... digits[3] = minute units
  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [CYC_W-1:0]                   cyc_cnt;
    logic                               pulse;
    logic                               relay;
    logic                               cyc_en;
    logic                               parity;
  } dwts_state_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour_now;
    logic [MIN_W-1:0]  minute_now;
    logic              relay_on;
    logic              pulse_level;
    logic              minute_rolled;
    logic [DIDX_W-1:0] digit_index;
    logic [SEG_W-1:0]  segment_code;
  } dwts_res_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] c;
    case (d)
      4'd0:    c = 8'h81;
      4'd1:    c = 8'hb7;
      4'd2:    c = 8'hc2;
      4'd3:    c = 8'h92;
      4'd4:    c = 8'hb4;
      4'd5:    c = 8'h98;
      4'd6:    c = 8'h88;
      4'd7:    c = 8'hb3;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h90;
      default: c = SEG_BLANK;
    endcase
    return c;
  endfunction

  // tens digit of a value below 64 (inputs here are saturated to < 60)
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [MIN_W-1:0] v);
    logic [DIGIT_W-1:0] t;
    if (v >= 6'd50)      t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic logic [6:0] bcd_to_bin(input logic [DIGIT_W-1:0] t,
                                            input logic [DIGIT_W-1:0] u);
    logic [6:0] tw;
    tw = {3'b000, t};
    return (tw << 3) + (tw << 1) + {3'b000, u};
  endfunction

  // minutes since midnight
  function automatic logic [TOD_W-1:0] tod(input logic [HOUR_W-1:0] h,
                                           input logic [MIN_W-1:0]  m);
    logic [TOD_W-1:0] hw;
    hw = {{(TOD_W-HOUR_W){1'b0}}, h};
    return (hw << 6) - (hw << 2) + {{(TOD_W-MIN_W){1'b0}}, m};
  endfunction

endpackage

[hw/rtl/dwts_step.sv]
// ----------------------------------------------------------------------------
// dwts_step
// Next-state and result logic for one item: tick slot counting, minute
// advance, window and cycle control, clock load and display digit lookup.
// ----------------------------------------------------------------------------
module dwts_step #(
  parameter int TICKS_PER_MINUTE = 30,
  parameter int SLOT_W           = 5
) (
  input  logic                        mode,
  input  logic [dwts_pkg::HOUR_W-1:0] set_hour,
  input  logic [dwts_pkg::MIN_W-1:0]  set_minute,
  input  dwts_pkg::dwts_cfg_t         cfg,
  input  dwts_pkg::dwts_state_t       st_q,
  input  logic [SLOT_W-1:0]           slot_q,
  output dwts_pkg::dwts_state_t       st_d,
  output logic [SLOT_W-1:0]           slot_d,
  output dwts_pkg::dwts_res_t         res
);

  logic [dwts_pkg::HOUR_W-1:0]  sh;
  logic [dwts_pkg::MIN_W-1:0]   sm;
  logic [dwts_pkg::DIGIT_W-1:0] h_t;
  logic [dwts_pkg::DIGIT_W-1:0] m_t;
  logic [dwts_pkg::NUM_DIGITS-1:0][dwts_pkg::DIGIT_W-1:0] adv;
  logic [dwts_pkg::HOUR_W-1:0]  h_now;
  logic [dwts_pkg::MIN_W-1:0]   m_now;
  logic [dwts_pkg::HOUR_W-1:0]  h_adv;
  logic [dwts_pkg::MIN_W-1:0]   m_adv;
  logic [dwts_pkg::CYC_W-1:0]   cnt_inc;
  logic                         last_slot;
  logic                         rolled;
  logic [dwts_pkg::DIDX_W-1:0]  didx;
  logic [dwts_pkg::SEG_W-1:0]   code;

  // saturate set time and split into BCD
  always_comb begin
    sh  = (set_hour > 5'd23) ? 5'd23 : set_hour;
    sm  = (set_minute > 6'd59) ? 6'd59 : set_minute;
    h_t = dwts_pkg::tens_of({1'b0, sh});
    m_t = dwts_pkg::tens_of(sm);
  end

  // minute advance with 23:59 wrap
  always_comb begin
    adv = st_q.digits;
    adv[3] = adv[3] + 4'd1;
    if (adv[3] >= 4'd10) begin
      adv[3] = 4'd0;
      adv[2] = adv[2] + 4'd1;
    end
    if (adv[2] >= 4'd6) begin
      adv[2] = 4'd0;
      adv[1] = adv[1] + 4'd1;
    end
    if (adv[1] >= 4'd10) begin
      adv[1] = 4'd0;
      adv[0] = adv[0] + 4'd1;
    end
    if (adv[0] == 4'd2 && adv[1] == 4'd4) begin
      adv = '0;
    end
    h_adv   = dwts_pkg::HOUR_W'(dwts_pkg::bcd_to_bin(adv[0], adv[1]));
    m_adv   = dwts_pkg::MIN_W'(dwts_pkg::bcd_to_bin(adv[2], adv[3]));
    cnt_inc = st_q.cyc_cnt + 8'd1;
  end

  assign last_slot = (slot_q == SLOT_W'(TICKS_PER_MINUTE - 1));

  always_comb begin
    st_d   = st_q;
    slot_d = slot_q;
    rolled = 1'b0;
    if (mode == dwts_pkg::MODE_SET) begin
      st_d.digits[0] = h_t;
      st_d.digits[1] = dwts_pkg::DIGIT_W'(sh - dwts_pkg::HOUR_W'(dwts_pkg::bcd_to_bin(h_t, 4'd0)));
      st_d.digits[2] = m_t;
      st_d.digits[3] = dwts_pkg::DIGIT_W'(sm - dwts_pkg::MIN_W'(dwts_pkg::bcd_to_bin(m_t, 4'd0)));
      slot_d         = '0;
      st_d.cyc_cnt   = '0;
      st_d.parity    = 1'b0;
      st_d.pulse     = 1'b0;
      if (dwts_pkg::tod(sh, sm) >= dwts_pkg::tod(cfg.start_hour, cfg.start_minute)) begin
        st_d.relay  = 1'b1;
        st_d.cyc_en = 1'b0;
      end else begin
        st_d.relay  = 1'b0;
        st_d.cyc_en = 1'b1;
      end
    end else if (!last_slot) begin
      slot_d = slot_q + SLOT_W'(1);
    end else begin
      slot_d      = '0;
      rolled      = 1'b1;
      st_d.digits = adv;
      if (st_q.cyc_en) begin
        st_d.cyc_cnt = cnt_inc;
        if (cnt_inc == cfg.cycle_minutes) begin
          st_d.cyc_cnt = '0;
          st_d.parity  = ~st_q.parity;
          st_d.pulse   = ~st_q.parity;
        end
      end
      if (h_adv == cfg.start_hour && m_adv == cfg.start_minute) begin
        st_d.relay   = 1'b1;
        st_d.pulse   = 1'b0;
        st_d.cyc_en  = 1'b0;
        st_d.cyc_cnt = '0;
      end
      if (h_adv == cfg.end_hour && m_adv == cfg.end_minute) begin
        st_d.relay  = 1'b0;
        st_d.cyc_en = 1'b1;
      end
    end
  end

  always_comb begin
    h_now = dwts_pkg::HOUR_W'(dwts_pkg::bcd_to_bin(st_d.digits[0], st_d.digits[1]));
    m_now = dwts_pkg::MIN_W'(dwts_pkg::bcd_to_bin(st_d.digits[2], st_d.digits[3]));
    didx  = slot_d[dwts_pkg::DIDX_W-1:0];
    code  = dwts_pkg::seg_code(st_d.digits[didx]);
    if (!didx[1]) begin
      code = code & dwts_pkg::SEG_DP_MASK;
    end
    res.hour_now      = h_now;
    res.minute_now    = m_now;
    res.relay_on      = st_d.relay;
    res.pulse_level   = st_d.pulse;
    res.minute_rolled = rolled;
    res.digit_index   = didx;
    res.segment_code  = code;
  end

endmodule

[hw/rtl/daily_window_time_switch_top.sv]
// ----------------------------------------------------------------------------
// daily_window_time_switch_top
// 24-hour BCD time switch with window relay, cycling pulse output and
// multiplexed seven-segment digit output.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | mode, set_hour, set_minute
//   out     | output    | out_valid/out_stall| time, relay, pulse, digit code
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Two register stages: input register, then result register; one word per
// cycle sustained while out_stall is low.
// All next-state logic sits between the input and result registers.
// rst_n is synchronous; after reset times are 00:00, relay on, end 12:00.
// out_stall holds the result register and backs up into in_stall.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module daily_window_time_switch_top #(
  parameter int TICKS_PER_MINUTE = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [dwts_pkg::HOUR_W-1:0]     in_set_hour,
  input  logic [dwts_pkg::MIN_W-1:0]      in_set_minute,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dwts_pkg::HOUR_W-1:0]     out_hour_now,
  output logic [dwts_pkg::MIN_W-1:0]      out_minute_now,
  output logic                            out_relay_on,
  output logic                            out_pulse_level,
  output logic                            out_minute_rolled,
  output logic [dwts_pkg::DIDX_W-1:0]     out_digit_index,
  output logic [dwts_pkg::SEG_W-1:0]      out_segment_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dwts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwts_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (TICKS_PER_MINUTE > 4) ? $clog2(TICKS_PER_MINUTE) : 2;

  logic                        in_vld_r;
  logic                        in_mode_r;
  logic [dwts_pkg::HOUR_W-1:0] in_hour_r;
  logic [dwts_pkg::MIN_W-1:0]  in_min_r;
  logic                        out_vld_r;
  dwts_pkg::dwts_res_t         res_r;
  dwts_pkg::dwts_res_t         res_nxt;
  dwts_pkg::dwts_cfg_t         cfg_r;
  dwts_pkg::dwts_state_t       st_r;
  dwts_pkg::dwts_state_t       st_nxt;
  logic [SLOT_W-1:0]           slot_r;
  logic [SLOT_W-1:0]           slot_nxt;
  logic                        adv;
  logic                        fire;
  logic                        in_acc;

  assign adv       = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && adv;
  assign in_stall  = in_vld_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  dwts_step #(
    .TICKS_PER_MINUTE (TICKS_PER_MINUTE),
    .SLOT_W           (SLOT_W)
  ) u_step (
    .mode       (in_mode_r),
    .set_hour   (in_hour_r),
    .set_minute (in_min_r),
    .cfg        (cfg_r),
    .st_q       (st_r),
    .slot_q     (slot_r),
    .st_d       (st_nxt),
    .slot_d     (slot_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_mode_r <= in_mode;
      in_hour_r <= in_set_hour;
      in_min_r  <= in_set_minute;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r      <= 1'b0;
      slot_r         <= '0;
      st_r.digits    <= '0;
      st_r.cyc_cnt   <= '0;
      st_r.pulse     <= 1'b0;
      st_r.relay     <= 1'b1;
      st_r.cyc_en    <= 1'b0;
      st_r.parity    <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
      slot_r    <= slot_nxt;
      st_r      <= st_nxt;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_hour    <= 5'd0;
      cfg_r.start_minute  <= 6'd0;
      cfg_r.end_hour      <= 5'd12;
      cfg_r.end_minute    <= 6'd0;
      cfg_r.cycle_minutes <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (dwts_pkg::cfg_reg_t'(cfg_index))
        dwts_pkg::REG_START_HOUR:    cfg_r.start_hour    <= cfg_data[dwts_pkg::HOUR_W-1:0];
        dwts_pkg::REG_START_MINUTE:  cfg_r.start_minute  <= cfg_data[dwts_pkg::MIN_W-1:0];
        dwts_pkg::REG_END_HOUR:      cfg_r.end_hour      <= cfg_data[dwts_pkg::HOUR_W-1:0];
        dwts_pkg::REG_END_MINUTE:    cfg_r.end_minute    <= cfg_data[dwts_pkg::MIN_W-1:0];
        dwts_pkg::REG_CYCLE_MINUTES: cfg_r.cycle_minutes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid         = out_vld_r;
  assign out_hour_now      = res_r.hour_now;
  assign out_minute_now    = res_r.minute_now;
  assign out_relay_on      = res_r.relay_on;
  assign out_pulse_level   = res_r.pulse_level;
  assign out_minute_rolled = res_r.minute_rolled;
  assign out_digit_index   = res_r.digit_index;
  assign out_segment_code  = res_r.segment_code;

endmodule
